### sv/sbr_pkg.sv
// Shared types, widths and ring helpers for the stream byte reassembler.
// No dependencies; imported by sbr_marks, the top level and the testbench files.
package sbr_pkg;

	localparam int WINDOW  = 64;
	localparam int IW      = $clog2(WINDOW);
	localparam int CW      = $clog2(WINDOW + 1);
	localparam int SW      = CW + 1;
	localparam int POS_W   = 32;
	localparam int BYTE_W  = 8;
	localparam int SPACE_W = 7;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_STORE = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_READ  = 5'b01000,
		ST_EMIT  = 5'b10000
	} sbr_state_t;

	typedef struct packed {
		logic          set_en;
		logic [IW-1:0] set_idx;
		logic          clr_en;
		logic [IW-1:0] clr_idx;
		logic [IW-1:0] rd_idx;
	} sbr_mark_ctl_t;

	// ring slot a + b, with b at most WINDOW
	function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] a, input logic [CW-1:0] b);
		logic [SW-1:0] s;
		begin
			s = {{(SW-IW){1'b0}}, a} + {1'b0, b};
			if (s >= SW'(WINDOW)) begin
				s = s - SW'(WINDOW);
			end
			return s[IW-1:0];
		end
	endfunction

endpackage

### sv/sbr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sbr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### sv/sbr_marks.sv
// Valid marks of the reassembly ring: one flop per slot, cleared at reset.
// Depends on sbr_pkg.
module sbr_marks
	import sbr_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  sbr_mark_ctl_t ctl,
	output logic          rd_bit
);

	logic [WINDOW-1:0] valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (ctl.set_en) begin
				valid_q[ctl.set_idx] <= 1'b1;
			end
			if (ctl.clr_en) begin
				valid_q[ctl.clr_idx] <= 1'b0;
			end
		end
	end

	assign rd_bit = valid_q[ctl.rd_idx];

endmodule

### sv/stream_byte_reassembler_core.sv
// Stream byte reassembler top level: sequencer, ring store and delivery.
// Depends on sbr_pkg, sbr_ram and sbr_marks.
//
//   channel  handshake            payload
//   request  req_valid/req_stall  kind, stream_index, data_byte, ends_stream,
//                                 downstream_space
//   result   rsp_valid/rsp_stall  out_valid, out_byte, last_of_run,
//                                 pending_count, stream_closed
//
// With a free result side an item passes the store state, a scan over the valid
// marks up to the first gap or the downstream space, then a RAM read and a
// result per delivered byte, and the idle state to take the next request.
// An item that delivers no byte gives one status result.
// After close an item goes straight from idle to one status result.
// Reset clears marks and stream state; the byte ring has no reset.
// A stalled result holds the sequencer in place; req_stall is high while busy.
module stream_byte_reassembler_core
	import sbr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic               kind,
	input  logic [POS_W-1:0]   stream_index,
	input  logic [BYTE_W-1:0]  data_byte,
	input  logic               ends_stream,
	input  logic [SPACE_W-1:0] downstream_space,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic               out_valid,
	output logic [BYTE_W-1:0]  out_byte,
	output logic               last_of_run,
	output logic [SPACE_W-1:0] pending_count,
	output logic               stream_closed
);

	sbr_state_t        state_q;
	logic              kind_q;
	logic [POS_W-1:0]  idx_q;
	logic [BYTE_W-1:0] byte_q;
	logic              ends_q;
	logic [CW-1:0]     space_q;
	logic [POS_W-1:0]  next_q;
	logic [IW-1:0]     head_q;
	logic [POS_W-1:0]  total_q;
	logic              end_known_q;
	logic [CW-1:0]     pending_q;
	logic              closed_q;
	logic [CW-1:0]     cnt_q;
	logic [IW-1:0]     rd_ptr_q;
	logic [CW-1:0]     remain_q;
	logic              data_res_q;

	logic [POS_W:0]    diff;
	logic              in_win;
	logic [IW-1:0]     store_slot;
	logic [CW-1:0]     space_sat;
	logic [POS_W-1:0]  next_n;
	logic              mark_bit;
	logic [BYTE_W-1:0] ram_rdata;
	logic              ram_we;
	logic              ram_re;
	sbr_mark_ctl_t     mark_ctl;

	assign diff       = {1'b0, idx_q} - {1'b0, next_q};
	assign in_win     = !kind_q && !diff[POS_W] && (diff[POS_W-1:0] < POS_W'(space_q));
	assign store_slot = ring_add(head_q, diff[CW-1:0]);
	assign space_sat  = (downstream_space > SPACE_W'(WINDOW)) ? CW'(WINDOW)
	                                                          : downstream_space[CW-1:0];
	assign next_n     = next_q + POS_W'(cnt_q);

	always_comb begin
		mark_ctl.set_en  = (state_q == ST_STORE) && in_win;
		mark_ctl.set_idx = store_slot;
		mark_ctl.clr_en  = (state_q == ST_READ);
		mark_ctl.clr_idx = rd_ptr_q;
		mark_ctl.rd_idx  = (state_q == ST_STORE) ? store_slot : ring_add(head_q, cnt_q);
		ram_we           = (state_q == ST_STORE) && in_win;
		ram_re           = (state_q == ST_READ);
	end

	sbr_marks u_marks (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mark_ctl),
		.rd_bit (mark_bit)
	);

	sbr_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (store_slot),
		.wdata (byte_q),
		.re    (ram_re),
		.raddr (rd_ptr_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			next_q      <= '0;
			head_q      <= '0;
			total_q     <= '0;
			end_known_q <= 1'b0;
			pending_q   <= '0;
			closed_q    <= 1'b0;
			cnt_q       <= '0;
			rd_ptr_q    <= '0;
			remain_q    <= '0;
			data_res_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						remain_q   <= '0;
						data_res_q <= 1'b0;
						state_q    <= closed_q ? ST_EMIT : ST_STORE;
					end
				end
				ST_STORE: begin
					if (in_win && !mark_bit) begin
						pending_q <= pending_q + CW'(1);
					end
					if (ends_q) begin
						total_q     <= idx_q + POS_W'(!kind_q);
						end_known_q <= 1'b1;
					end
					cnt_q   <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if ((cnt_q < space_q) && mark_bit) begin
						cnt_q <= cnt_q + CW'(1);
					end else begin
						next_q    <= next_n;
						pending_q <= pending_q - cnt_q;
						head_q    <= ring_add(head_q, cnt_q);
						rd_ptr_q  <= head_q;
						remain_q  <= cnt_q;
						if (end_known_q && (total_q == next_n)) begin
							closed_q <= 1'b1;
						end
						data_res_q <= 1'b0;
						state_q    <= (cnt_q == '0) ? ST_EMIT : ST_READ;
					end
				end
				ST_READ: begin
					rd_ptr_q   <= ring_add(rd_ptr_q, CW'(1));
					remain_q   <= remain_q - CW'(1);
					data_res_q <= 1'b1;
					state_q    <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!rsp_stall) begin
						state_q <= (remain_q == '0) ? ST_IDLE : ST_READ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request payload capture
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && req_valid) begin
			kind_q  <= kind;
			idx_q   <= stream_index;
			byte_q  <= data_byte;
			ends_q  <= ends_stream;
			space_q <= space_sat;
		end
	end

	assign req_stall     = (state_q != ST_IDLE);
	assign rsp_valid     = (state_q == ST_EMIT);
	assign out_valid     = data_res_q;
	assign out_byte      = data_res_q ? ram_rdata : '0;
	assign last_of_run   = (remain_q == '0);
	assign pending_count = SPACE_W'(pending_q);
	assign stream_closed = closed_q;

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted but block not busy");

	a_closed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		closed_q |=> closed_q)
		else $error("stream reopened after close");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= CW'(WINDOW))
		else $error("pending count above ring depth");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !out_valid |-> last_of_run)
		else $error("status result not marked last");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> cnt_q <= space_q)
		else $error("scan ran past downstream space");

endmodule

### tb/sbr_tb_pkg.sv
// Testbench-side codes for the stream byte reassembler: the segment kinds.
// No dependencies; imported by the checker and by the testbench top.
package sbr_tb_pkg;

	typedef enum logic {
		KIND_DATA  = 1'b0,
		KIND_EMPTY = 1'b1
	} seg_kind_t;

endpackage

### tb/sbr_checker.sv
// Scoreboard for the stream byte reassembler: predicts the results of every
// accepted request and compares them with the result channel in order.
// Depends on sbr_pkg and sbr_tb_pkg.
module sbr_checker
	import sbr_pkg::*;
	import sbr_tb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_stall,
	input  logic               kind,
	input  logic [POS_W-1:0]   stream_index,
	input  logic [BYTE_W-1:0]  data_byte,
	input  logic               ends_stream,
	input  logic [SPACE_W-1:0] downstream_space,
	input  logic               rsp_valid,
	input  logic               rsp_stall,
	input  logic               out_valid,
	input  logic [BYTE_W-1:0]  out_byte,
	input  logic               last_of_run,
	input  logic [SPACE_W-1:0] pending_count,
	input  logic               stream_closed,
	output int                 fail_count,
	output int                 results_owed,
	output logic [POS_W-1:0]   stream_next
);

	typedef struct {
		logic               valid;
		logic [BYTE_W-1:0]  data;
		logic               last;
		logic [SPACE_W-1:0] pending;
		logic               closed;
	} delivery_t;

	delivery_t          owed[$];
	logic [BYTE_W-1:0]  ring_data [WINDOW];
	logic               ring_mark [WINDOW];
	logic [IW-1:0]      head;
	logic [POS_W:0]     end_pos;
	logic               end_seen;
	logic [SPACE_W-1:0] stored;
	logic               closed;

	task automatic owe(input logic v, input logic [BYTE_W-1:0] b, input logic l);
		delivery_t d;
		d.valid   = v;
		d.data    = b;
		d.last    = l;
		d.pending = stored;
		d.closed  = closed;
		owed.push_back(d);
	endtask

	task automatic reassemble(input logic k, input logic [POS_W-1:0] pos,
			input logic [BYTE_W-1:0] b, input logic ends, input logic [SPACE_W-1:0] sp);
		logic [SPACE_W-1:0] room;
		logic [IW-1:0]      slot;
		logic [BYTE_W-1:0]  run[$];
		if (closed) begin
			owe(1'b0, '0, 1'b1);
			return;
		end
		room = (sp > SPACE_W'(WINDOW)) ? SPACE_W'(WINDOW) : sp;
		if (k == KIND_DATA && pos >= stream_next &&
				{1'b0, pos} < {1'b0, stream_next} + (POS_W+1)'(room)) begin
			slot = head + IW'(pos - stream_next);
			if (!ring_mark[slot]) begin
				stored = stored + SPACE_W'(1);
			end
			ring_mark[slot] = 1'b1;
			ring_data[slot] = b;
		end
		while (run.size() < int'(room) && ring_mark[head]) begin
			run.push_back(ring_data[head]);
			ring_mark[head] = 1'b0;
			head = head + IW'(1);
			stream_next = stream_next + POS_W'(1);
			stored = stored - SPACE_W'(1);
		end
		if (ends) begin
			end_pos = {1'b0, pos} + (POS_W+1)'(k == KIND_DATA);
			end_seen = 1'b1;
		end
		// close check uses the low 32 bits of the end position
		if (end_seen && end_pos[POS_W-1:0] == stream_next) begin
			closed = 1'b1;
		end
		if (run.size() == 0) begin
			owe(1'b0, '0, 1'b1);
		end else begin
			foreach (run[i]) begin
				owe(1'b1, run[i], i == run.size() - 1);
			end
		end
	endtask

	task automatic compare_field(input string field, input logic [POS_W-1:0] want,
			input logic [POS_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
			fail_count++;
		end
	endtask

	task automatic check_result();
		delivery_t want;
		if (owed.size() == 0) begin
			$display("%0t: unexpected result: expected none, actual out_valid=%0b out_byte=%0h",
				$time, out_valid, out_byte);
			fail_count++;
			return;
		end
		want = owed.pop_front();
		compare_field("out_valid", POS_W'(want.valid), POS_W'(out_valid));
		compare_field("out_byte", POS_W'(want.data), POS_W'(out_byte));
		compare_field("last_of_run", POS_W'(want.last), POS_W'(last_of_run));
		compare_field("pending_count", POS_W'(want.pending), POS_W'(pending_count));
		compare_field("stream_closed", POS_W'(want.closed), POS_W'(stream_closed));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (ring_mark[i]) begin
				ring_mark[i] = 1'b0;
			end
			owed.delete();
			stream_next  = '0;
			head         = '0;
			end_pos      = '0;
			end_seen     = 1'b0;
			stored       = '0;
			closed       = 1'b0;
			fail_count   = 0;
			results_owed = 0;
		end else begin
			if (req_valid && !req_stall) begin
				reassemble(kind, stream_index, data_byte, ends_stream, downstream_space);
			end
			if (rsp_valid && !rsp_stall) begin
				check_result();
			end
			results_owed = owed.size();
		end
	end

endmodule

### tb/testbench.sv
// Testbench top for stream_byte_reassembler_core: clock, reset, request
// stimulus and result-side stalls; sbr_checker predicts and compares.
// Depends on sbr_pkg, sbr_tb_pkg, sbr_checker and the block itself.
module testbench;
	import sbr_pkg::*;
	import sbr_tb_pkg::*;

	localparam int ITEM_GOAL   = 330;
	localparam int CYCLE_LIMIT = 1000000;

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_stall;
	logic               kind;
	logic [POS_W-1:0]   stream_index;
	logic [BYTE_W-1:0]  data_byte;
	logic               ends_stream;
	logic [SPACE_W-1:0] downstream_space;
	logic               rsp_valid;
	logic               rsp_stall;
	logic               out_valid;
	logic [BYTE_W-1:0]  out_byte;
	logic               last_of_run;
	logic [SPACE_W-1:0] pending_count;
	logic               stream_closed;

	int               fail_count;
	int               results_owed;
	logic [POS_W-1:0] stream_next;
	int               items_sent;
	int               quiet_left;
	int               cycle_count;

	stream_byte_reassembler_core dut (.*);

	sbr_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("testbench failed");
				$finish;
			end
		end
	end

	// result side: free stretches, short stalls, now and then a long one
	initial begin
		rsp_stall = 1'b0;
		forever begin
			rsp_stall = 1'b0;
			repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4))
				@(negedge clk);
			rsp_stall = 1'b1;
			repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3))
				@(negedge clk);
		end
	end

	function automatic int sender_gap();
		int r;
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			quiet_left = $urandom_range(20, 50);
		end
		if (r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(6, 40);
	endfunction

	function automatic logic [SPACE_W-1:0] pick_space();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return SPACE_W'(WINDOW);
		end
		if (r < 85) begin
			return SPACE_W'($urandom_range(WINDOW + 1, 127));
		end
		return SPACE_W'($urandom_range(0, WINDOW - 1));
	endfunction

	task automatic send_item(input seg_kind_t k, input logic [POS_W-1:0] pos,
			input logic [BYTE_W-1:0] b, input logic ends, input logic [SPACE_W-1:0] sp);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid        = 1'b1;
		kind             = k;
		stream_index     = pos;
		data_byte        = b;
		ends_stream      = ends;
		downstream_space = sp;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic wait_drained();
		req_valid = 1'b0;
		do @(negedge clk); while (results_owed != 0);
	endtask

	// one segment, a byte per request, in shuffled or reversed order
	task automatic send_segment(input logic [POS_W-1:0] base, input int len,
			input bit reversed, input bit ends_last);
		int order[$];
		int j;
		int t;
		logic [SPACE_W-1:0] sp;
		for (int i = 0; i < len; i++) begin
			order.push_back(i);
		end
		if (reversed) begin
			order.reverse();
		end else begin
			for (int i = len - 1; i > 0; i--) begin
				j = $urandom_range(0, i);
				t = order[i];
				order[i] = order[j];
				order[j] = t;
			end
		end
		foreach (order[i]) begin
			sp = (reversed || ends_last) ? SPACE_W'(WINDOW) : pick_space();
			send_item(KIND_DATA, base + order[i], 8'($urandom), ends_last && order[i] == len - 1, sp);
			if (!ends_last && $urandom_range(0, 9) == 0) begin
				send_item(KIND_DATA, base + order[i], 8'($urandom), 1'b0, sp);
			end
		end
	endtask

	task automatic send_noise();
		case ($urandom_range(0, 4))
			0: send_item(KIND_DATA, $urandom, 8'($urandom), 1'b0, 7'($urandom));
			1: send_item(KIND_DATA, stream_next + $urandom_range(0, 90), 8'($urandom), 1'b0,
				7'($urandom));
			2: send_item(KIND_DATA, stream_next - $urandom_range(1, 12), 8'($urandom), 1'b0,
				7'($urandom));
			3: send_item(KIND_EMPTY, stream_next + $urandom_range(0, 20), 8'($urandom), 1'b0,
				7'($urandom));
			// end mark far ahead, replaced before the stream gets there
			default: send_item(seg_kind_t'($urandom_range(0, 1)),
				stream_next + 20000 + $urandom_range(0, 1000000), 8'($urandom), 1'b1,
				7'($urandom));
		endcase
	endtask

	initial begin
		int base;
		int len;
		bit did_full;
		arst_n           = 1'b0;
		req_valid        = 1'b0;
		kind             = KIND_DATA;
		stream_index     = '0;
		data_byte        = '0;
		ends_stream      = 1'b0;
		downstream_space = '0;
		items_sent       = 0;
		quiet_left       = 0;
		did_full         = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_item(KIND_DATA, 32'd0, 8'hA5, 1'b0, 7'd0);        // no space: dropped
		send_item(KIND_DATA, 32'd2, 8'h00, 1'b0, 7'd64);
		send_item(KIND_DATA, 32'd1, 8'hFF, 1'b0, 7'd64);
		send_item(KIND_DATA, 32'd0, 8'h11, 1'b0, 7'd64);       // releases three
		send_item(KIND_DATA, 32'hFFFF_FFFF, 8'h5A, 1'b1, 7'd64); // end mark wraps past 2^32
		send_item(KIND_EMPTY, 32'd3, 8'hC3, 1'b0, 7'd64);
		send_item(KIND_DATA, 32'd5, 8'h22, 1'b0, 7'd127);      // space saturates
		send_item(KIND_DATA, 32'd5, 8'h33, 1'b0, 7'd65);       // overwrite
		send_item(KIND_DATA, 32'd67, 8'h77, 1'b0, 7'd64);      // just past the window
		send_item(KIND_DATA, 32'd66, 8'h44, 1'b0, 7'd64);      // last slot of the window
		send_item(KIND_DATA, 32'd4, 8'h66, 1'b0, 7'd2);
		send_item(KIND_DATA, 32'd3, 8'h55, 1'b0, 7'd2);        // delivery capped by space
		send_item(KIND_EMPTY, 32'h0000_1000, 8'h00, 1'b1, 7'd0);
		send_item(KIND_DATA, 32'd2, 8'h99, 1'b0, 7'd64);       // already delivered
		send_item(KIND_EMPTY, 32'd5, 8'h00, 1'b0, 7'd64);
		send_item(KIND_DATA, 32'h8000_0000, 8'hFF, 1'b1, 7'd64); // later end mark wins
		send_item(KIND_DATA, 32'd7, 8'h0F, 1'b0, 7'd1);
		send_item(KIND_DATA, 32'd6, 8'hF0, 1'b0, 7'd1);
		wait_drained();

		while (items_sent < ITEM_GOAL) begin
			if (items_sent >= 180 && !did_full) begin
				wait_drained();
				send_segment(stream_next, WINDOW, 1'b1, 1'b0);
				did_full = 1'b1;
			end else if ($urandom_range(0, 99) < 75) begin
				base = stream_next + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0);
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
				send_segment(base, len, 1'b0, 1'b0);
			end else begin
				repeat ($urandom_range(1, 3)) send_noise();
			end
		end

		wait_drained();
		send_segment(stream_next, 8, 1'b0, 1'b1);
		wait_drained();
		send_item(KIND_EMPTY, stream_next, 8'h00, 1'b1, 7'd0);
		repeat (4) send_noise();                               // ignored once closed
		req_valid = 1'b0;

		while (results_owed != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		if (fail_count == 0 && results_owed == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
